// ===== hw/rtl/mm_pkg.sv =====
// shared types, constants and helpers of the matrix multiply core
package mm_pkg;

	localparam int MAX_DIM    = 8;
	localparam int IDX_W      = $clog2(MAX_DIM);
	localparam int DIM_W      = 4;
	localparam int DATA_W     = 16;
	localparam int FRAC_W     = 8;
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int DEPTH      = MAX_DIM * MAX_DIM;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int ACC_W      = PROD_W + IDX_W;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
	localparam logic [MODE_W-1:0] MODE_START  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_ERROR  = 2'd2,
		CMD_START  = 2'd3
	} cmd_kind_t;

	// shape held as dimension minus one
	typedef struct packed {
		logic [IDX_W-1:0] ra_m1;
		logic [IDX_W-1:0] n_m1;
		logic [IDX_W-1:0] cb_m1;
	} dims_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] value;
		dims_t             dims;
	} cmd_t;

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [IDX_W-1:0] dim_m1(input logic [DIM_W-1:0] r);
		logic [IDX_W-1:0] res;
		priority if (r == '0) begin
			res = '0;
		end else if (r > DIM_W'(MAX_DIM)) begin
			res = IDX_W'(MAX_DIM - 1);
		end else begin
			res = IDX_W'(r - DIM_W'(1));
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/mm_front.sv =====
// front end: accepts input words and turns them into queued commands
module mm_front (
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [mm_pkg::MODE_W-1:0]     mode,
	input  logic [mm_pkg::IDX_W-1:0]      row,
	input  logic [mm_pkg::IDX_W-1:0]      col,
	input  logic signed [mm_pkg::DATA_W-1:0] value,
	input  mm_pkg::dims_t                 dims,
	input  logic                          fifo_full,
	output logic                          push,
	output mm_pkg::cmd_t                  cmd
);

	logic useful;

	assign item_ready = !fifo_full;

	always_comb begin
		useful     = 1'b1;
		cmd.kind   = mm_pkg::CMD_START;
		cmd.row    = row;
		cmd.col    = col;
		cmd.value  = value;
		cmd.dims   = dims;
		unique case (mode)
			mm_pkg::MODE_LOAD_A: begin
				if (row > dims.ra_m1 || col > dims.n_m1) begin
					cmd.kind = mm_pkg::CMD_ERROR;
				end else begin
					cmd.kind = mm_pkg::CMD_LOAD_A;
				end
			end
			mm_pkg::MODE_LOAD_B: begin
				if (row > dims.n_m1 || col > dims.cb_m1) begin
					cmd.kind = mm_pkg::CMD_ERROR;
				end else begin
					cmd.kind = mm_pkg::CMD_LOAD_B;
				end
			end
			mm_pkg::MODE_START: begin
				cmd.kind = mm_pkg::CMD_START;
			end
			default: begin
				useful = 1'b0;
			end
		endcase
	end

	assign push = item_valid && !fifo_full && useful;

endmodule

// ===== hw/rtl/mm_cmd_fifo.sv =====
// short command queue between front and back end
module mm_cmd_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  mm_pkg::cmd_t wdata,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output mm_pkg::cmd_t rdata
);

	mm_pkg::cmd_t               buf_q [mm_pkg::FIFO_DEPTH];
	logic [mm_pkg::PTR_W-1:0]   wr_ptr_q;
	logic [mm_pkg::PTR_W-1:0]   rd_ptr_q;
	logic [mm_pkg::CNT_W-1:0]   count_q;
	logic                       do_push;
	logic                       do_pop;

	assign full      = (count_q == mm_pkg::CNT_W'(mm_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + mm_pkg::PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + mm_pkg::PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + mm_pkg::CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - mm_pkg::CNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/mm_back.sv =====
// back end: element stores, multiply-accumulate walk and result register
module mm_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  mm_pkg::cmd_t                    cmd,
	output logic                            cmd_pop,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [mm_pkg::IDX_W-1:0]        out_row,
	output logic [mm_pkg::IDX_W-1:0]        out_col,
	output logic signed [mm_pkg::DATA_W-1:0] out_value,
	output logic                            status,
	output logic                            last
);

	localparam int SH_W = mm_pkg::ACC_W - mm_pkg::FRAC_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_MAC   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t                         state_q;
	logic [mm_pkg::IDX_W-1:0]       i_q;
	logic [mm_pkg::IDX_W-1:0]       j_q;
	logic [mm_pkg::IDX_W-1:0]       k_q;
	mm_pkg::dims_t                  dims_q;

	logic [mm_pkg::DATA_W-1:0]      mem_a_q [mm_pkg::DEPTH];
	logic [mm_pkg::DATA_W-1:0]      mem_b_q [mm_pkg::DEPTH];
	logic signed [mm_pkg::DATA_W-1:0] rd_a_s1;
	logic signed [mm_pkg::DATA_W-1:0] rd_b_s1;
	logic                           vld_s1;
	logic                           first_s1;
	logic                           lst_s1;
	logic signed [mm_pkg::PROD_W-1:0] prod_s2;
	logic                           vld_s2;
	logic                           first_s2;
	logic                           lst_s2;
	logic signed [mm_pkg::ACC_W-1:0] acc_q;
	logic                           done_q;

	logic                           out_valid_q;
	logic [mm_pkg::IDX_W-1:0]       out_row_q;
	logic [mm_pkg::IDX_W-1:0]       out_col_q;
	logic [mm_pkg::DATA_W-1:0]      out_value_q;
	logic                           status_q;
	logic                           last_q;

	logic                           out_free;
	logic                           we_a;
	logic                           we_b;
	logic                           load_err;
	logic                           start;
	logic                           issue;
	logic                           emit;
	logic                           run_end;
	logic [mm_pkg::ADDR_W-1:0]      waddr;
	logic [mm_pkg::ADDR_W-1:0]      raddr_a;
	logic [mm_pkg::ADDR_W-1:0]      raddr_b;
	logic signed [SH_W-1:0]         shifted;
	logic [mm_pkg::DATA_W-1:0]      sat_value;

	assign out_free = !out_valid_q || result_ready;
	assign waddr    = {cmd.row, cmd.col};
	assign raddr_a  = {i_q, k_q};
	assign raddr_b  = {k_q, j_q};
	assign run_end  = (i_q == dims_q.ra_m1) && (j_q == dims_q.cb_m1);

	always_comb begin
		cmd_pop  = 1'b0;
		we_a     = 1'b0;
		we_b     = 1'b0;
		load_err = 1'b0;
		start    = 1'b0;
		issue    = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						mm_pkg::CMD_LOAD_A: begin
							cmd_pop = 1'b1;
							we_a    = 1'b1;
						end
						mm_pkg::CMD_LOAD_B: begin
							cmd_pop = 1'b1;
							we_b    = 1'b1;
						end
						mm_pkg::CMD_ERROR: begin
							cmd_pop  = out_free;
							load_err = out_free;
						end
						mm_pkg::CMD_START: begin
							cmd_pop = 1'b1;
							start   = 1'b1;
						end
						default: begin
							cmd_pop = 1'b0;
						end
					endcase
				end
			end
			ST_MAC: begin
				issue = 1'b1;
			end
			ST_DRAIN: begin
				emit = done_q && out_free;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	// floor shift, then saturate to the data width
	always_comb begin
		shifted = SH_W'(acc_q >>> mm_pkg::FRAC_W);
		if ((&shifted[SH_W-1:mm_pkg::DATA_W-1]) || !(|shifted[SH_W-1:mm_pkg::DATA_W-1])) begin
			sat_value = shifted[mm_pkg::DATA_W-1:0];
		end else if (shifted[SH_W-1]) begin
			sat_value = {1'b1, {(mm_pkg::DATA_W-1){1'b0}}};
		end else begin
			sat_value = {1'b0, {(mm_pkg::DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a_q[waddr] <= cmd.value;
		end
		rd_a_s1 <= mem_a_q[raddr_a];
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b_q[waddr] <= cmd.value;
		end
		rd_b_s1 <= mem_b_q[raddr_b];
	end

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		lst_s1   <= (k_q == dims_q.n_m1);
		prod_s2  <= rd_a_s1 * rd_b_s1;
		first_s2 <= first_s1;
		lst_s2   <= lst_s1;
		if (vld_s2) begin
			if (first_s2) begin
				acc_q <= mm_pkg::ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + mm_pkg::ACC_W'(prod_s2);
			end
		end
		if (start) begin
			dims_q <= cmd.dims;
		end
		if (load_err) begin
			out_row_q   <= cmd.row;
			out_col_q   <= cmd.col;
			out_value_q <= '0;
			status_q    <= 1'b1;
			last_q      <= 1'b1;
		end else if (emit) begin
			out_row_q   <= i_q;
			out_col_q   <= j_q;
			out_value_q <= sat_value;
			status_q    <= 1'b0;
			last_q      <= run_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (vld_s2 && lst_s2) begin
				done_q <= 1'b1;
			end else if (emit) begin
				done_q <= 1'b0;
			end
			if (load_err || emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (k_q == dims_q.n_m1) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + mm_pkg::IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (emit) begin
						if (run_end) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_MAC;
							if (j_q == dims_q.cb_m1) begin
								j_q <= '0;
								i_q <= i_q + mm_pkg::IDX_W'(1);
							end else begin
								j_q <= j_q + mm_pkg::IDX_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign out_value    = out_value_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

// ===== hw/rtl/matrix_multiply_core.sv =====
// top level of the fixed-point matrix multiply core
// usage:
//   set the shape with cfg_we/cfg_index/cfg_data (rows_a, inner_dim, cols_b) while idle
//   input words on item_valid/item_ready: mode 0 loads an A element, mode 1 a B element,
//   mode 2 starts a run, mode 3 is taken and dropped
//   result words on result_valid/result_ready: one per product element, row-major,
//   last set on the final one; a load outside the shape gives one word with status set
//   the front end checks each word against the shape and queues it (four deep), so
//   input words keep flowing while the back end works or the receiver stalls
//   a load goes into its store once the back end is idle; an error word once the result
//   register is free
//   a run forms one product element at a time by the multiply-accumulate walk
//   (one store read per step, read, multiply and add stages)
//   when the receiver stalls the result register holds and the walk waits,
//   then the queue fills and item_ready drops
//   reset clears the shape to one by one and empties the queue; stored elements
//   read as unknown until written
module matrix_multiply_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mm_pkg::DIM_W-1:0]         cfg_data,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic [mm_pkg::MODE_W-1:0]        mode,
	input  logic [mm_pkg::IDX_W-1:0]         row,
	input  logic [mm_pkg::IDX_W-1:0]         col,
	input  logic signed [mm_pkg::DATA_W-1:0] value,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [mm_pkg::IDX_W-1:0]         out_row,
	output logic [mm_pkg::IDX_W-1:0]         out_col,
	output logic signed [mm_pkg::DATA_W-1:0] out_value,
	output logic                             status,
	output logic                             last
);

	logic [mm_pkg::DIM_W-1:0] rows_a_q;
	logic [mm_pkg::DIM_W-1:0] inner_dim_q;
	logic [mm_pkg::DIM_W-1:0] cols_b_q;
	mm_pkg::dims_t            dims;
	mm_pkg::cmd_t             push_cmd;
	mm_pkg::cmd_t             head_cmd;
	logic                     push;
	logic                     fifo_full;
	logic                     fifo_not_empty;
	logic                     pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= mm_pkg::DIM_W'(1);
			inner_dim_q <= mm_pkg::DIM_W'(1);
			cols_b_q    <= mm_pkg::DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mm_pkg::REG_ROWS_A:    rows_a_q    <= cfg_data;
				mm_pkg::REG_INNER_DIM: inner_dim_q <= cfg_data;
				mm_pkg::REG_COLS_B:    cols_b_q    <= cfg_data;
				default: begin
					rows_a_q <= rows_a_q;
				end
			endcase
		end
	end

	assign dims.ra_m1 = mm_pkg::dim_m1(rows_a_q);
	assign dims.n_m1  = mm_pkg::dim_m1(inner_dim_q);
	assign dims.cb_m1 = mm_pkg::dim_m1(cols_b_q);

	mm_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.mode       (mode),
		.row        (row),
		.col        (col),
		.value      (value),
		.dims       (dims),
		.fifo_full  (fifo_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	mm_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (push_cmd),
		.full      (fifo_full),
		.pop       (pop),
		.not_empty (fifo_not_empty),
		.rdata     (head_cmd)
	);

	mm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (fifo_not_empty),
		.cmd          (head_cmd),
		.cmd_pop      (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_value    (out_value),
		.status       (status),
		.last         (last)
	);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for the matrix multiply core: shaped loads and runs against a product predictor
import mm_pkg::*;

typedef struct {
	logic [IDX_W-1:0]         row_no;
	logic [IDX_W-1:0]         col_no;
	logic signed [DATA_W-1:0] elem;
	logic                     status;
	logic                     last;
} result_word_t;

class product_board;
	logic [DIM_W-1:0]         shape [3];
	logic signed [DATA_W-1:0] mat_a [DEPTH];
	logic signed [DATA_W-1:0] mat_b [DEPTH];
	bit                       held_a [DEPTH];
	bit                       held_b [DEPTH];
	result_word_t             owed [$];
	int                       mismatches;
	int                       seen;
	int                       faults_seen;

	function new();
		foreach (shape[i]) shape[i] = DIM_W'(1);
		foreach (held_a[i]) begin
			held_a[i] = 1'b0;
			held_b[i] = 1'b0;
		end
		mismatches  = 0;
		seen        = 0;
		faults_seen = 0;
	endfunction

	function int span(int idx);
		int d;
		d = int'(shape[idx]);
		if (d == 0) begin
			d = 1;
		end else if (d > MAX_DIM) begin
			d = MAX_DIM;
		end
		return d;
	endfunction

	// floor shift back to q8.8, then clamp to the data width
	function logic signed [DATA_W-1:0] q88_clamp(longint acc);
		longint hi, lo, s;
		hi = (longint'(1) << (DATA_W - 1)) - 1;
		lo = -hi - 1;
		s  = acc >>> FRAC_W;
		if (s > hi) begin
			s = hi;
		end else if (s < lo) begin
			s = lo;
		end
		return DATA_W'(s);
	endfunction

	function void note_word(logic [MODE_W-1:0] m, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
			logic signed [DATA_W-1:0] v);
		int           ra, n, cb, rlim, clim;
		longint       acc;
		result_word_t w;
		ra = span(REG_ROWS_A);
		n  = span(REG_INNER_DIM);
		cb = span(REG_COLS_B);
		if (m == MODE_LOAD_A || m == MODE_LOAD_B) begin
			rlim = (m == MODE_LOAD_A) ? ra : n;
			clim = (m == MODE_LOAD_A) ? n : cb;
			if (int'(r) >= rlim || int'(c) >= clim) begin
				w.row_no = r;
				w.col_no = c;
				w.elem   = '0;
				w.status = 1'b1;
				w.last   = 1'b1;
				owed.push_back(w);
			end else if (m == MODE_LOAD_A) begin
				mat_a[int'(r) * MAX_DIM + int'(c)]  = v;
				held_a[int'(r) * MAX_DIM + int'(c)] = 1'b1;
			end else begin
				mat_b[int'(r) * MAX_DIM + int'(c)]  = v;
				held_b[int'(r) * MAX_DIM + int'(c)] = 1'b1;
			end
		end else if (m == MODE_START) begin
			for (int i = 0; i < ra; i++) begin
				for (int j = 0; j < cb; j++) begin
					acc = 0;
					for (int k = 0; k < n; k++) begin
						acc += longint'(mat_a[i * MAX_DIM + k]) * longint'(mat_b[k * MAX_DIM + j]);
					end
					w.row_no = IDX_W'(i);
					w.col_no = IDX_W'(j);
					w.elem   = q88_clamp(acc);
					w.status = 1'b0;
					w.last   = (i == ra - 1 && j == cb - 1);
					owed.push_back(w);
				end
			end
		end
	endfunction

	function void field_check(string what, logic signed [DATA_W-1:0] want,
			logic signed [DATA_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	function void check_result(result_word_t got);
		result_word_t want;
		seen++;
		if (got.status === 1'b1) faults_seen++;
		if (owed.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result, expected none, got row %0d col %0d value %0d",
				$time, got.row_no, got.col_no, got.elem);
			return;
		end
		want = owed.pop_front();
		field_check("out_row", DATA_W'(want.row_no), DATA_W'(got.row_no));
		field_check("out_col", DATA_W'(want.col_no), DATA_W'(got.col_no));
		field_check("out_value", want.elem, got.elem);
		field_check("status", DATA_W'(want.status), DATA_W'(got.status));
		field_check("last", DATA_W'(want.last), DATA_W'(got.last));
	endfunction
endclass

module tb_top;
	localparam int     HALF_PERIOD = 10;
	localparam int     LONG_HOLD   = 300;
	localparam int     SETTLE      = 32;
	localparam int     WORD_GOAL   = 370;
	localparam longint TIMEOUT_NS  = 40_000_000;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [DIM_W-1:0]         cfg_data;
	logic                     item_valid;
	logic                     item_ready;
	logic [MODE_W-1:0]        mode;
	logic [IDX_W-1:0]         row;
	logic [IDX_W-1:0]         col;
	logic signed [DATA_W-1:0] value;
	logic                     result_valid;
	logic                     result_ready;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic signed [DATA_W-1:0] out_value;
	logic                     status;
	logic                     last;

	product_board board;
	bit           hold_req;
	bit           steady_tx;
	int           words_sent;
	int           loads_sent;
	int           starts_sent;
	int           dropped_sent;
	int           shapes_run;

	matrix_multiply_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.mode         (mode),
		.row          (row),
		.col          (col),
		.value        (value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_value    (out_value),
		.status       (status),
		.last         (last)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic int rand_gap();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_elem();
		int                       pick;
		logic signed [DATA_W-1:0] res;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			case ($urandom_range(0, 4))
				0: res = 16'sh7fff;
				1: res = 16'sh8000;
				2: res = 16'sh0000;
				3: res = 16'shffff;
				default: res = 16'sh0100;
			endcase
		end else if (pick < 65) begin
			res = DATA_W'(int'($urandom_range(0, 2048)) - 1024);
		end else begin
			res = DATA_W'($urandom);
		end
		return res;
	endfunction

	function automatic logic [DIM_W-1:0] rand_dim();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) return '0;
		if (pick < 18) return DIM_W'($urandom_range(5, 15));
		return DIM_W'($urandom_range(1, 4));
	endfunction

	task automatic send_word(input logic [MODE_W-1:0] m, input int r, input int c,
			input logic signed [DATA_W-1:0] v);
		int gap;
		gap = (steady_tx || $urandom_range(0, 99) < 60) ? 0 : rand_gap();
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		mode       <= m;
		row        <= IDX_W'(r);
		col        <= IDX_W'(c);
		value      <= v;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		board.note_word(m, IDX_W'(r), IDX_W'(c), v);
		if (m == MODE_SPARE) begin
			dropped_sent++;
		end else begin
			words_sent++;
			if (m == MODE_START) starts_sent++;
			else loads_sent++;
		end
	endtask

	// stop offering words and wait for every owed result
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (board.owed.size() != 0) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_we           <= 1'b1;
		cfg_index        <= idx;
		cfg_data         <= val;
		board.shape[idx] = val;
	endtask

	task automatic write_shape(input logic [DIM_W-1:0] ra_w, n_w, cb_w);
		drain();
		// loads leave no result behind, so give the queue time to empty
		repeat (SETTLE) @(negedge clk);
		put_reg(REG_ROWS_A, ra_w);
		put_reg(REG_INNER_DIM, n_w);
		put_reg(REG_COLS_B, cb_w);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [DIM_W-1:0] ra_w, n_w, cb_w, input bit squeeze);
		int                ra, n, cb, body, pick, starts, rlim, clim, r, c;
		logic [MODE_W-1:0] m;
		write_shape(ra_w, n_w, cb_w);
		shapes_run++;
		ra        = board.span(REG_ROWS_A);
		n         = board.span(REG_INNER_DIM);
		cb        = board.span(REG_COLS_B);
		steady_tx = ($urandom_range(0, 3) == 0);
		// operands for the shape, some entries kept from earlier shapes
		for (int i = 0; i < ra; i++) begin
			for (int k = 0; k < n; k++) begin
				if (!board.held_a[i * MAX_DIM + k] || $urandom_range(0, 3) != 0) begin
					send_word(MODE_LOAD_A, i, k, rand_elem());
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			for (int j = 0; j < cb; j++) begin
				if (!board.held_b[k * MAX_DIM + j] || $urandom_range(0, 3) != 0) begin
					send_word(MODE_LOAD_B, k, j, rand_elem());
				end
			end
		end
		if (squeeze) begin
			// receiver holds off while words keep coming, so the input stalls
			hold_req  = 1'b1;
			steady_tx = 1'b1;
			send_word(MODE_START, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
			for (int q = 0; q < 16; q++) begin
				m = ($urandom_range(0, 1) == 0) ? MODE_LOAD_A : MODE_LOAD_B;
				send_word(m, $urandom_range(0, ((m == MODE_LOAD_A) ? ra : n) - 1),
					$urandom_range(0, ((m == MODE_LOAD_A) ? n : cb) - 1), rand_elem());
			end
			steady_tx = 1'b0;
		end
		body   = $urandom_range(8, 24);
		starts = 0;
		repeat (body) begin
			pick = $urandom_range(0, 99);
			m    = ($urandom_range(0, 1) == 0) ? MODE_LOAD_A : MODE_LOAD_B;
			rlim = (m == MODE_LOAD_A) ? ra : n;
			clim = (m == MODE_LOAD_A) ? n : cb;
			if (pick >= 67 && pick < 90 && (ra * cb <= 16 || starts == 0)) begin
				send_word(MODE_START, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
				starts++;
			end else if (pick >= 62 && pick < 67) begin
				send_word(MODE_SPARE, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
			end else if (pick >= 50 && pick < 62 && (rlim < MAX_DIM || clim < MAX_DIM)) begin
				if (clim == MAX_DIM || (rlim < MAX_DIM && $urandom_range(0, 1) == 0)) begin
					r = $urandom_range(rlim, MAX_DIM - 1);
					c = $urandom_range(0, MAX_DIM - 1);
				end else begin
					r = $urandom_range(0, MAX_DIM - 1);
					c = $urandom_range(clim, MAX_DIM - 1);
				end
				send_word(m, r, c, rand_elem());
			end else if (pick >= 90 && pick < 94) begin
				drain();
			end else begin
				send_word(m, $urandom_range(0, rlim - 1), $urandom_range(0, clim - 1),
					rand_elem());
			end
		end
		send_word(MODE_START, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
	endtask

	always @(posedge clk) begin : result_mon
		result_word_t got;
		if (arst_n && result_valid && result_ready) begin
			got.row_no = out_row;
			got.col_no = out_col;
			got.elem   = out_value;
			got.status = status;
			got.last   = last;
			board.check_result(got);
		end
	end

	initial begin : rx_side
		int stall_left;
		int calm_left;
		int pick;
		stall_left = 0;
		calm_left  = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = LONG_HOLD;
				calm_left  = 0;
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else if (calm_left > 0) begin
				result_ready <= 1'b1;
				calm_left--;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					calm_left = $urandom_range(50, 200);
					result_ready <= 1'b1;
				end else if (pick < 75) begin
					result_ready <= 1'b1;
				end else begin
					stall_left = rand_gap() - 1;
					result_ready <= 1'b0;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		item_valid   = 1'b0;
		mode         = '0;
		row          = '0;
		col          = '0;
		value        = '0;
		result_ready = 1'b0;
		hold_req     = 1'b0;
		steady_tx    = 1'b0;
		words_sent   = 0;
		loads_sent   = 0;
		starts_sent  = 0;
		dropped_sent = 0;
		shapes_run   = 0;
		board        = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one by one shape out of reset: saturation both ways, floor on negatives
		send_word(MODE_LOAD_A, 0, 0, 16'sh7fff);
		send_word(MODE_LOAD_B, 0, 0, 16'sh7fff);
		send_word(MODE_START, 0, 0, 16'sh0000);
		send_word(MODE_LOAD_B, 0, 0, 16'sh8000);
		send_word(MODE_START, 7, 7, 16'shffff);
		send_word(MODE_LOAD_A, 0, 0, 16'sh8000);
		send_word(MODE_START, 0, 0, 16'sh8000);
		send_word(MODE_LOAD_A, 0, 0, 16'shffff);
		send_word(MODE_LOAD_B, 0, 0, 16'sh0001);
		send_word(MODE_START, 0, 0, 16'sh0000);
		// loads outside the shape, and a spare mode word
		send_word(MODE_LOAD_A, 7, 0, 16'sh1234);
		send_word(MODE_LOAD_A, 0, 7, 16'sh7fff);
		send_word(MODE_LOAD_B, 7, 7, 16'sh8000);
		send_word(MODE_SPARE, 7, 7, 16'shffff);
		send_word(MODE_LOAD_A, 0, 0, 16'sh0100);
		send_word(MODE_LOAD_B, 0, 0, 16'shfe80);
		send_word(MODE_START, 0, 0, 16'sh0000);

		// shape extremes first, zero and oversize registers among them
		run_phase(4'd8, 4'd8, 4'd8, 1'b0);
		run_phase(4'd0, 4'd15, 4'd3, 1'b0);
		run_phase(4'd2, 4'd3, 4'd4, 1'b1);
		run_phase(4'd15, 4'd1, 4'd0, 1'b0);
		run_phase(4'd1, 4'd8, 4'd1, 1'b0);
		while (words_sent < WORD_GOAL) begin
			run_phase(rand_dim(), rand_dim(), rand_dim(), 1'b0);
		end

		drain();
		repeat (64) @(posedge clk);
		$display("covered %0d words (%0d loads, %0d runs) and %0d spare mode words over %0d shapes",
			words_sent, loads_sent, starts_sent, dropped_sent, shapes_run);
		$display("checked %0d results, %0d range errors among them, %0d mismatches",
			board.seen, board.faults_seen, board.mismatches);
		if (board.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
